### rtl/grqp_pkg.sv
package grqp_pkg;

    localparam int SUM_W          = 34;
    localparam int PIX_W          = 10;
    localparam int THR_W          = 10;
    localparam int CFG_W          = 13;
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [1:0] MODE_1BIT = 2'd0;
    localparam logic [1:0] MODE_4BIT = 2'd1;

    localparam logic [1:0] REG_DEPTH_MODE   = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    typedef struct packed {
        logic       cmd;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_padding;
        logic       row_done;
        logic       image_done;
    } out_item_t;

    // queued item: command plus r+g+b
    typedef struct packed {
        logic             cmd;
        logic [PIX_W-1:0] pix_sum;
    } q_entry_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_res_t;

endpackage

### rtl/grqp_front.sv
module grqp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  grqp_pkg::in_item_t in_item,
    output grqp_pkg::q_entry_t head,
    output logic               head_valid,
    input  logic               pop
);
    import grqp_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    q_entry_t         mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             push;
    q_entry_t         entry;

    assign in_stall   = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign push       = in_valid && !in_stall;
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        entry.cmd     = in_item.cmd;
        entry.pix_sum = PIX_W'(in_item.red) + PIX_W'(in_item.green) + PIX_W'(in_item.blue);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

### rtl/grqp_div.sv
module grqp_div #(
    parameter int DEN_W = 26
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [grqp_pkg::SUM_W-1:0] dividend,
    input  logic [DEN_W-1:0]           divisor,
    output grqp_pkg::div_res_t         res
);
    import grqp_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [SUM_W-1:0]   dq_reg, dq_next;
    logic [DEN_W:0]     trial;
    logic               ge;

    // restoring division, one quotient bit per cycle; dq holds the
    // dividend bits still to come on top and the quotient bits below
    assign trial = {rem_reg, dq_reg[SUM_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        dq_next   = dq_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = divisor;
            dq_next   = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            dq_next  = {dq_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        dq_reg  <= dq_next;
    end

    assign res.done     = done_reg;
    assign res.quotient = dq_reg;

endmodule

### rtl/grqp_back.sv
module grqp_back #(
    parameter int MAX_WIDTH  = grqp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = grqp_pkg::DEF_MAX_HEIGHT,
    localparam int CW = ($clog2(MAX_WIDTH + 1) < grqp_pkg::CFG_W) ?
                        $clog2(MAX_WIDTH + 1) : grqp_pkg::CFG_W,
    localparam int RW = ($clog2(MAX_HEIGHT + 1) < grqp_pkg::CFG_W) ?
                        $clog2(MAX_HEIGHT + 1) : grqp_pkg::CFG_W
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  grqp_pkg::q_entry_t         head,
    input  logic                       head_valid,
    output logic                       pop,
    input  logic [1:0]                 depth_mode,
    input  logic [grqp_pkg::CFG_W-1:0] image_width,
    input  logic [grqp_pkg::CFG_W-1:0] image_height,
    output logic                       div_start,
    output logic [grqp_pkg::SUM_W-1:0] div_dividend,
    output logic [CW+RW-1:0]           div_divisor,
    input  grqp_pkg::div_res_t         div_res,
    output logic                       out_valid,
    input  logic                       out_stall,
    output grqp_pkg::out_item_t        out_item
);
    import grqp_pkg::*;

    // round(s/51) = (2s+51)/102 and round(s/3) = (2s+3)/6 by reciprocal
    localparam int Q4_MUL   = 2571;
    localparam int Q4_SHIFT = 18;
    localparam int Q8_MUL   = 10923;
    localparam int Q8_SHIFT = 16;

    typedef enum logic [2:0] {
        ST_RUN = 3'b001,
        ST_DIV = 3'b010,
        ST_PAD = 3'b100
    } back_state_t;

    back_state_t      state_reg, state_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [THR_W-1:0] thr_reg, thr_next;
    logic             thr_valid_reg, thr_valid_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [7:0]       pack_reg, pack_next;
    logic [2:0]       pos_reg, pos_next;
    logic [1:0]       pad_cnt_reg, pad_cnt_next;
    logic             pad_img_reg, pad_img_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_item_reg, out_item_next;

    logic [CW-1:0]    w;
    logic [RW-1:0]    h;
    logic [2:0]       last_slot;
    logic [2:0]       slot;
    logic [10:0]      x4, x8;
    logic [22:0]      p4;
    logic [24:0]      p8;
    logic [3:0]       v4;
    logic [7:0]       v8;
    logic [7:0]       val_shifted;
    logic [7:0]       new_byte;
    logic [CW:0]      col_inc;
    logic [RW:0]      row_inc;
    logic [CW:0]      w_round8;
    logic [CW:0]      w_round2;
    logic [1:0]       bytes_lo;
    logic [1:0]       pad;
    logic             row_end;
    logic             img_end;
    logic             emit;
    logic             out_free;
    logic             out_load;

    always_comb
    begin
        if (image_width == '0)
            w = CW'(1);
        else if (32'(image_width) > MAX_WIDTH)
            w = CW'(MAX_WIDTH);
        else
            w = CW'(image_width);
        if (image_height == '0)
            h = RW'(1);
        else if (32'(image_height) > MAX_HEIGHT)
            h = RW'(MAX_HEIGHT);
        else
            h = RW'(image_height);
    end

    assign div_dividend = sum_reg;
    assign div_divisor  = (CW+RW)'(w) * (CW+RW)'(h);

    assign x4 = 11'({head.pix_sum, 1'b0}) + 11'd51;
    assign x8 = 11'({head.pix_sum, 1'b0}) + 11'd3;
    assign p4 = 23'(x4) * 23'(Q4_MUL);
    assign p8 = 25'(x8) * 25'(Q8_MUL);
    assign v4 = p4[Q4_SHIFT +: 4];
    assign v8 = p8[Q8_SHIFT +: 8];

    assign w_round8 = {1'b0, w} + (CW+1)'(7);
    assign w_round2 = {1'b0, w} + (CW+1)'(1);

    always_comb
    begin
        unique case (depth_mode)
            MODE_1BIT:
            begin
                last_slot = 3'd7;
                bytes_lo  = w_round8[4:3];
            end
            MODE_4BIT:
            begin
                last_slot = 3'd1;
                bytes_lo  = w_round2[2:1];
            end
            default:
            begin
                last_slot = 3'd0;
                bytes_lo  = w[1:0];
            end
        endcase
        // a position left past the last slot by a mode change closes the byte
        slot = (pos_reg < last_slot) ? pos_reg : last_slot;
        unique case (depth_mode)
            MODE_1BIT:
                val_shifted = (head.pix_sum > thr_reg) ? (8'd1 << (3'd7 - slot)) : 8'd0;
            MODE_4BIT:
                val_shifted = (slot == 3'd0) ? {v4, 4'd0} : {4'd0, v4};
            default:
                val_shifted = v8;
        endcase
    end

    assign new_byte = pack_reg | val_shifted;
    assign col_inc  = {1'b0, col_reg} + 1'b1;
    assign row_inc  = {1'b0, row_reg} + 1'b1;
    assign row_end  = (col_inc >= {1'b0, w});
    assign img_end  = row_end && (row_inc >= {1'b0, h});
    assign emit     = (slot == last_slot) || row_end;
    assign pad      = 2'(2'd0 - bytes_lo);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        thr_next       = thr_reg;
        thr_valid_next = thr_valid_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        pack_next      = pack_reg;
        pos_next       = pos_reg;
        pad_cnt_next   = pad_cnt_reg;
        pad_img_next   = pad_img_reg;
        out_item_next  = out_item_reg;
        out_load       = 1'b0;
        pop            = 1'b0;
        div_start      = 1'b0;

        unique case (state_reg)
            ST_RUN:
            begin
                if (head_valid)
                begin
                    if (!head.cmd)
                    begin
                        sum_next = sum_reg + SUM_W'(head.pix_sum);
                        pop      = 1'b1;
                    end
                    else if (!thr_valid_reg)
                    begin
                        // first pack item of the frame: latch the mean, item waits
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else if (out_free)
                    begin
                        pop = 1'b1;
                        if (emit)
                        begin
                            out_load                 = 1'b1;
                            out_item_next.out_byte   = new_byte;
                            out_item_next.is_padding = 1'b0;
                            out_item_next.row_done   = row_end && (pad == 2'd0);
                            out_item_next.image_done = img_end && (pad == 2'd0);
                            pack_next                = 8'd0;
                            pos_next                 = 3'd0;
                        end
                        else
                        begin
                            pack_next = new_byte;
                            pos_next  = slot + 1'b1;
                        end
                        if (row_end)
                        begin
                            col_next = '0;
                            if (img_end)
                            begin
                                row_next       = '0;
                                sum_next       = '0;
                                thr_next       = '0;
                                thr_valid_next = 1'b0;
                            end
                            else
                            begin
                                row_next = RW'(row_inc);
                            end
                            if (pad != 2'd0)
                            begin
                                pad_cnt_next = pad;
                                pad_img_next = img_end;
                                state_next   = ST_PAD;
                            end
                        end
                        else
                        begin
                            col_next = CW'(col_inc);
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    thr_next = (|div_res.quotient[SUM_W-1:THR_W]) ?
                               {THR_W{1'b1}} : div_res.quotient[THR_W-1:0];
                    thr_valid_next = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            ST_PAD:
            begin
                if (out_free)
                begin
                    out_load                 = 1'b1;
                    out_item_next.out_byte   = 8'd0;
                    out_item_next.is_padding = 1'b1;
                    out_item_next.row_done   = (pad_cnt_reg == 2'd1);
                    out_item_next.image_done = pad_img_reg && (pad_cnt_reg == 2'd1);
                    pad_cnt_next             = pad_cnt_reg - 1'b1;
                    if (pad_cnt_reg == 2'd1)
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            sum_reg       <= '0;
            thr_reg       <= '0;
            thr_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            pack_reg      <= '0;
            pos_reg       <= '0;
            pad_cnt_reg   <= '0;
            pad_img_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            thr_reg       <= thr_next;
            thr_valid_reg <= thr_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            pack_reg      <= pack_next;
            pos_reg       <= pos_next;
            pad_cnt_reg   <= pad_cnt_next;
            pad_img_reg   <= pad_img_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

### rtl/gray_quantize_row_pack.sv
// A byte-closing pixel item passes the FIFO and then the output register to show its byte.
// Throughput: one item per cycle unless the output stalls or a divide or pad burst runs;
// items queue in a 4-entry FIFO ahead of the packer. The first pack item of a frame waits
// while the 34-step serial divider forms the mean; a row end adds 0 to 3 pad bytes.
// Reset: control state clears at once, config returns to mode 0, width 1, height 1.
module gray_quantize_row_pack #(
    parameter int MAX_WIDTH  = grqp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = grqp_pkg::DEF_MAX_HEIGHT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  grqp_pkg::in_item_t         in_item,
    output logic                       out_valid,
    input  logic                       out_stall,
    output grqp_pkg::out_item_t        out_item,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [grqp_pkg::CFG_W-1:0] cfg_data
);
    import grqp_pkg::*;

    localparam int CW = ($clog2(MAX_WIDTH + 1) < CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int RW = ($clog2(MAX_HEIGHT + 1) < CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

    logic [1:0]       mode_reg, mode_next;
    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;

    q_entry_t         head;
    logic             head_valid;
    logic             pop;
    logic             div_start;
    logic [SUM_W-1:0] div_dividend;
    logic [CW+RW-1:0] div_divisor;
    div_res_t         div_res;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        mode_next   = mode_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DEPTH_MODE:   mode_next   = cfg_data[1:0];
                REG_IMAGE_WIDTH:  width_next  = cfg_data;
                REG_IMAGE_HEIGHT: height_next = cfg_data;
                default:          mode_next   = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_1BIT;
            width_reg  <= CFG_W'(1);
            height_reg <= CFG_W'(1);
        end
        else
        begin
            mode_reg   <= mode_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    grqp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    grqp_div #(
        .DEN_W (CW + RW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .res      (div_res)
    );

    grqp_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .depth_mode   (mode_reg),
        .image_width  (width_reg),
        .image_height (height_reg),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_res      (div_res),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_item     (out_item)
    );

endmodule

### rtl/grqp_port_check.sv
module grqp_port_check (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input grqp_pkg::out_item_t out_item
);

    // stalled item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("output item changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.is_padding |-> out_item.out_byte == 8'd0)
        else $error("padding byte not zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.image_done |-> out_item.row_done)
        else $error("image end without row end");

    // pad bytes of a row follow each other without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_item.is_padding && !out_item.row_done
        |=> out_valid && out_item.is_padding)
        else $error("gap inside row padding");

endmodule

bind gray_quantize_row_pack grqp_port_check u_port_check (.*);

### sim/tb_gray_quantize_row_pack.sv
`timescale 1ns / 1ps

module tb_gray_quantize_row_pack;
    import grqp_pkg::*;

    localparam logic [1:0] MODE_8BIT  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;    // unused code, behaves as 8-bit
    localparam logic [1:0] REG_NONE   = 2'd3;    // no register at this index
    localparam logic       CMD_ACCUM  = 1'b0;
    localparam logic       CMD_PACK   = 1'b1;

    localparam int ITEM_TARGET      = 360;
    localparam int SETTLE_CYCLES    = 64;        // divider, FIFO and pad burst, with margin
    localparam int LONG_HOLD_CYCLES = 220;
    localparam int WATCHDOG_LIMIT   = 3000;

    class row_pack_scoreboard;
        logic [1:0]       depth;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        logic [33:0]      pixel_sum;
        logic [9:0]       threshold;
        bit               threshold_set;
        int unsigned      column;
        int unsigned      row;
        logic [7:0]       partial_byte;
        int unsigned      fill_pos;
        out_item_t        expected_bytes[$];
        int unsigned      errors;
        int unsigned      pixels;
        int unsigned      packs;
        int unsigned      checked;

        function new();
            depth         = MODE_1BIT;
            width_reg     = 1;
            height_reg    = 1;
            pixel_sum     = '0;
            threshold     = '0;
            threshold_set = 1'b0;
            column        = 0;
            row           = 0;
            partial_byte  = '0;
            fill_pos      = 0;
            errors        = 0;
            pixels        = 0;
            packs         = 0;
            checked       = 0;
        endfunction

        function void apply_register(logic [1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_DEPTH_MODE:   depth = data[1:0];
                REG_IMAGE_WIDTH:  width_reg = data;
                REG_IMAGE_HEIGHT: height_reg = data;
                default: ;
            endcase
        endfunction

        // accepted pixel item -> bytes it releases
        function void note_pixel(in_item_t px);
            int unsigned level;
            int unsigned w;
            int unsigned h;
            int unsigned per_byte;
            int unsigned val;
            int unsigned shift;
            int unsigned slot;
            int unsigned row_bytes;
            int unsigned pad;
            int unsigned n;
            logic [63:0] mean;
            out_item_t   res[4];
            bit          row_end;

            level = px.red + px.green + px.blue;
            w = (width_reg == 0) ? 1 : ((width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg);
            h = (height_reg == 0) ? 1 :
                ((height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : height_reg);
            pixels++;
            if (px.cmd == CMD_ACCUM)
            begin
                pixel_sum = pixel_sum + 34'(level);
                return;
            end
            packs++;

            if (!threshold_set)
            begin
                mean = 64'(pixel_sum) / (64'(w) * 64'(h));
                threshold = (mean > 64'd1023) ? 10'd1023 : mean[9:0];
                threshold_set = 1'b1;
            end

            case (depth)
                MODE_1BIT: per_byte = 8;
                MODE_4BIT: per_byte = 2;
                default:   per_byte = 1;
            endcase
            // a position left over from a denser mode closes the byte
            slot = (fill_pos < per_byte) ? fill_pos : per_byte - 1;

            if (depth == MODE_1BIT)
            begin
                val   = (level > threshold) ? 1 : 0;
                shift = 7 - slot;
            end
            else if (depth == MODE_4BIT)
            begin
                val   = (2 * level + 51) / 102;
                shift = 4 * (1 - slot);
            end
            else
            begin
                val   = (2 * level + 3) / 6;
                shift = 0;
            end
            partial_byte = partial_byte | 8'(val << shift);

            column++;
            row_end = (column >= w);
            n = 0;
            if (slot == per_byte - 1 || row_end)
            begin
                res[n] = '0;
                res[n].out_byte = partial_byte;
                n++;
                partial_byte = '0;
                fill_pos = 0;
            end
            else
            begin
                fill_pos = slot + 1;
            end

            if (row_end)
            begin
                case (depth)
                    MODE_1BIT: row_bytes = (w + 7) / 8;
                    MODE_4BIT: row_bytes = (w + 1) / 2;
                    default:   row_bytes = w;
                endcase
                pad = (4 - (row_bytes & 3)) & 3;
                repeat (pad)
                begin
                    res[n] = '0;
                    res[n].is_padding = 1'b1;
                    n++;
                end
                res[n-1].row_done = 1'b1;
                column = 0;
                row++;
                if (row >= h)
                begin
                    res[n-1].image_done = 1'b1;
                    row           = 0;
                    pixel_sum     = '0;
                    threshold     = '0;
                    threshold_set = 1'b0;
                end
            end

            for (int i = 0; i < n; i++)
                expected_bytes.push_back(res[i]);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_byte(out_item_t got);
            out_item_t want;
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected output item, expected none, got %h", $time, got);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            checked++;
            compare_field("out_byte", want.out_byte, got.out_byte);
            compare_field("is_padding", 8'(want.is_padding), 8'(got.is_padding));
            compare_field("row_done", 8'(want.row_done), 8'(got.row_done));
            compare_field("image_done", 8'(want.image_done), 8'(got.image_done));
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    in_item_t         in_item = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_item_t        out_item;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    row_pack_scoreboard sb = new();

    bit          src_idle = 1'b1;
    bit          sink_idle = 1'b1;
    bit          hold_results = 1'b0;
    int unsigned sent = 0;
    int unsigned settings = 0;
    int          quiet_cycles = 0;

    gray_quantize_row_pack dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_pixel(in_item);
            if (out_valid && !out_stall)
                sb.check_byte(out_item);
            if (cfg_valid && cfg_ready)
                sb.apply_register(cfg_index, cfg_data);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // output side back-pressure
    always
    begin : result_pacer
        @(posedge clk);
        if (hold_results)
        begin
            out_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clk);
            out_stall <= 1'b0;
            hold_results = 1'b0;
        end
        else if (sink_idle && $urandom_range(0, 11) == 0)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    function automatic logic [7:0] rand_channel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom());
        endcase
    endfunction

    // leaves in_valid high after the item is taken
    task automatic send_pixel(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        if (src_idle && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{cmd: cmd, red: r, green: g, blue: b};
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic send_random(logic cmd);
        send_pixel(cmd, rand_channel(), rand_channel(), rand_channel());
    endtask

    // stop input, wait for every pending byte, then let the pipe go quiet
    task automatic pause_input();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_bytes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(logic [1:0] idx, logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic new_setting(logic [1:0] mode, int unsigned w, int unsigned h);
        pause_input();
        set_register(REG_DEPTH_MODE, CFG_W'(mode));
        set_register(REG_IMAGE_WIDTH, CFG_W'(w));
        set_register(REG_IMAGE_HEIGHT, CFG_W'(h));
        settings++;
    endtask

    initial
    begin
        logic [1:0]  mode;
        int unsigned w;
        int unsigned h;
        int unsigned cut;
        int unsigned pick;
        int          frame;
        bit          broken;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 8-bit rounding edges, an accumulate item that is ignored for output
        new_setting(MODE_8BIT, 3, 2);
        send_pixel(CMD_PACK, 8'd0, 8'd0, 8'd0);
        send_pixel(CMD_ACCUM, 8'd255, 8'd255, 8'd255);
        send_pixel(CMD_PACK, 8'd255, 8'd255, 8'd255);
        send_pixel(CMD_PACK, 8'd1, 8'd0, 8'd0);
        send_pixel(CMD_PACK, 8'd1, 8'd1, 8'd0);
        send_pixel(CMD_PACK, 8'd128, 8'd127, 8'd0);
        send_pixel(CMD_PACK, 8'd0, 8'd0, 8'd3);

        // 4-bit rounding around s = 25/26, full scale, odd width
        new_setting(MODE_4BIT, 5, 1);
        send_pixel(CMD_PACK, 8'd25, 8'd0, 8'd0);
        send_pixel(CMD_PACK, 8'd0, 8'd26, 8'd0);
        send_pixel(CMD_PACK, 8'd255, 8'd255, 8'd255);
        send_pixel(CMD_PACK, 8'd0, 8'd0, 8'd0);
        send_pixel(CMD_PACK, 8'd0, 8'd0, 8'd50);

        // sum over more pixels than W*H: mean clips at 1023
        new_setting(MODE_1BIT, 1, 1);
        send_pixel(CMD_ACCUM, 8'd255, 8'd255, 8'd255);
        send_pixel(CMD_ACCUM, 8'd255, 8'd255, 8'd255);
        send_pixel(CMD_PACK, 8'd255, 8'd255, 8'd255);

        // zero mean, then switch to 8-bit in mid row so the open byte closes
        new_setting(MODE_1BIT, 8, 1);
        send_pixel(CMD_PACK, 8'd0, 8'd0, 8'd0);
        send_pixel(CMD_PACK, 8'd0, 8'd0, 8'd1);
        send_pixel(CMD_PACK, 8'd128, 8'd0, 8'd0);
        send_pixel(CMD_PACK, 8'd0, 8'd0, 8'd0);
        send_pixel(CMD_PACK, 8'd0, 8'd255, 8'd0);
        pause_input();
        set_register(REG_DEPTH_MODE, CFG_W'(MODE_8BIT));
        send_pixel(CMD_PACK, 8'd200, 8'd10, 8'd90);
        send_pixel(CMD_PACK, 8'd7, 8'd7, 8'd7);
        send_pixel(CMD_PACK, 8'd60, 8'd60, 8'd61);

        // spare mode code, width 0 used as 1, height clipped to max
        new_setting(MODE_SPARE, 0, 8191);
        send_pixel(CMD_PACK, 8'd17, 8'd34, 8'd51);
        send_pixel(CMD_PACK, 8'd255, 8'd0, 8'd255);

        // width beyond max, partial row only; unused register index
        new_setting(MODE_1BIT, 8191, 4096);
        set_register(REG_NONE, '1);
        send_pixel(CMD_PACK, 8'd255, 8'd255, 8'd255);
        send_pixel(CMD_PACK, 8'd0, 8'd0, 8'd0);

        frame = 0;
        while (sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                mode = MODE_1BIT;
            else if (pick < 7)
                mode = MODE_4BIT;
            else if (pick < 9)
                mode = MODE_8BIT;
            else
                mode = MODE_SPARE;
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            h = $urandom_range(1, 3);

            if (sent >= ITEM_TARGET - 60)
            begin
                src_idle  = 1'b0;
                sink_idle = 1'b0;
            end
            else
            begin
                src_idle  = ($urandom_range(0, 3) != 0);
                sink_idle = ($urandom_range(0, 3) != 0);
            end

            // output held off while a dense 8-bit image streams in
            if (frame == 0)
            begin
                mode     = MODE_8BIT;
                w        = 12;
                h        = 2;
                src_idle = 1'b0;
            end

            new_setting(mode, w, h);
            if (frame == 0)
                hold_results = 1'b1;

            broken = ($urandom_range(0, 9) == 0);
            cut    = $urandom_range(0, w * h - 1);
            if (mode == MODE_1BIT)
                repeat (w * h) send_random(CMD_ACCUM);
            for (int k = 0; k < w * h; k++)
            begin
                if (broken && k == cut)
                    break;
                if ($urandom_range(0, 11) == 0)
                    send_random(1'($urandom_range(0, 1)));
                send_random(CMD_PACK);
            end
            frame++;
        end

        pause_input();
        $display("Run covered %0d pixel items (%0d packed) and %0d checked output items",
                 sb.pixels, sb.packs, sb.checked);
        $display("over %0d depth/size settings with idle bursts and a long output hold",
                 settings);
        if (sb.errors == 0 && sb.expected_bytes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
